// ===== rtl/scc_pkg.sv =====
`default_nettype none
package scc_pkg;

    localparam int COORD_BITS  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int DIFF_W      = COORD_BITS + 1;    // start/dest/body differences
    localparam int MUL_W       = DIFF_W + 1;        // signed multiplier operand
    localparam int PROD_W      = 2 * MUL_W;
    localparam int HALF_W      = DIFF_W;            // limb of a split wide operand
    localparam int SQ_W        = 2 * HALF_W;        // a, positive c, |h|
    localparam int ACC_W       = 2 * SQ_W + 2;
    localparam int H_W         = SQ_W + 1;          // signed h and c
    localparam int N_W         = SQ_W + 2;          // signed -h - s
    localparam int RAD_W       = 2 * SQ_W;
    localparam int ROOT_W      = SQ_W;
    localparam int SREM_W      = ROOT_W + 3;
    localparam int T_W         = FRAC_BITS + 1;
    localparam int DIST_W      = 16;
    localparam int MARG_W      = 8;
    localparam int DVD_W       = MARG_W + FRAC_BITS;
    localparam int QUO_W       = DVD_W + 1;
    localparam int DREM_W      = SQ_W + 1;
    localparam int CNT_W       = 6;
    localparam int STEP_W      = 5;
    localparam int SQRT_STEPS  = RAD_W / 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_DIST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 3'd3;

    localparam logic [DIST_W-1:0] RST_BLOCK_DIST   = 16'd512;
    localparam logic [DIST_W-1:0] RST_BLOCK_HEIGHT = 16'd512;
    localparam logic [MARG_W-1:0] RST_STOP_MARGIN  = 8'd13;
    localparam logic [MARG_W-1:0] RST_MIN_LENGTH   = 8'd3;
    localparam logic [T_W-1:0]    FRAC_ONE         = T_W'(1) << FRAC_BITS;

    // micro-op step numbers of the multiply-accumulate sequence
    localparam logic [CNT_W-1:0] MAC1_LAST   = 6'd7;
    localparam logic [CNT_W-1:0] MAC2_FIRST  = 6'd8;
    localparam logic [CNT_W-1:0] MAC2_LAST   = 6'd15;
    localparam logic [CNT_W-1:0] SCALE_FIRST = 6'd16;
    localparam logic [CNT_W-1:0] SCALE_LAST  = 6'd18;
    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] DIVF_LAST   = CNT_W'(FRAC_BITS - 1);
    localparam logic [CNT_W-1:0] DIVM_LAST   = CNT_W'(DVD_W - 1);

    typedef enum logic [3:0] {
        OPD_DX, OPD_DY, OPD_FX, OPD_FY, OPD_R, OPD_HL, OPD_HH,
        OPD_AL, OPD_AH, OPD_CL, OPD_CH, OPD_STOP
    } t_opnd;

    typedef enum logic [1:0] {SH0, SH1, SH2} t_shift;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} t_acc_mode;
    typedef enum logic [2:0] {SV_NONE, SV_A, SV_C, SV_H, SV_X, SV_Y} t_save;
    typedef enum logic {SQS_DISC, SQS_LEN} t_sq_src;
    typedef enum logic {DVS_FRAC, DVS_MARGIN} t_dv_src;

    typedef struct packed {
        t_opnd     opa;
        t_opnd     opb;
        t_shift    sh;
        t_acc_mode mode;
        t_save     save;
    } t_mop;

    typedef struct packed {
        logic              load;
        logic              mac;
        logic [STEP_W-1:0] step;
        logic              sq_init;
        t_sq_src           sq_src;
        logic              sq_step;
        logic              dv_init;
        t_dv_src           dv_src;
        logic              dv_step;
        logic              upd_zero;
        logic              upd_div;
        logic              set_stop;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic c_le0;
        logic disc_neg;
        logic n_ok;
        logic clip;
        logic last;
        logic out_busy;
    } t_sts;

    // a = dx^2+dy^2, c = |f|^2-r^2, h = f.d, h^2-a*c in 25-bit limbs, d*stop
    function automatic t_mop mop_of(input logic [STEP_W-1:0] s);
        t_mop m;
        m = '{OPD_DX, OPD_DX, SH0, ACC_HOLD, SV_NONE};
        case (s)
            5'd0:    m = '{OPD_DX, OPD_DX,   SH0, ACC_LOAD, SV_NONE};
            5'd1:    m = '{OPD_DY, OPD_DY,   SH0, ACC_ADD,  SV_NONE};
            5'd2:    m = '{OPD_FX, OPD_FX,   SH0, ACC_LOAD, SV_A};
            5'd3:    m = '{OPD_FY, OPD_FY,   SH0, ACC_ADD,  SV_NONE};
            5'd4:    m = '{OPD_R,  OPD_R,    SH0, ACC_SUB,  SV_NONE};
            5'd5:    m = '{OPD_FX, OPD_DX,   SH0, ACC_LOAD, SV_C};
            5'd6:    m = '{OPD_FY, OPD_DY,   SH0, ACC_ADD,  SV_NONE};
            5'd7:    m = '{OPD_DX, OPD_DX,   SH0, ACC_HOLD, SV_H};
            5'd8:    m = '{OPD_HL, OPD_HL,   SH0, ACC_LOAD, SV_NONE};
            5'd9:    m = '{OPD_HL, OPD_HH,   SH1, ACC_ADD,  SV_NONE};
            5'd10:   m = '{OPD_HH, OPD_HL,   SH1, ACC_ADD,  SV_NONE};
            5'd11:   m = '{OPD_HH, OPD_HH,   SH2, ACC_ADD,  SV_NONE};
            5'd12:   m = '{OPD_AL, OPD_CL,   SH0, ACC_SUB,  SV_NONE};
            5'd13:   m = '{OPD_AL, OPD_CH,   SH1, ACC_SUB,  SV_NONE};
            5'd14:   m = '{OPD_AH, OPD_CL,   SH1, ACC_SUB,  SV_NONE};
            5'd15:   m = '{OPD_AH, OPD_CH,   SH2, ACC_SUB,  SV_NONE};
            5'd16:   m = '{OPD_DX, OPD_STOP, SH0, ACC_LOAD, SV_NONE};
            5'd17:   m = '{OPD_DY, OPD_STOP, SH0, ACC_LOAD, SV_X};
            5'd18:   m = '{OPD_DX, OPD_DX,   SH0, ACC_HOLD, SV_Y};
            default: m = '{OPD_DX, OPD_DX,   SH0, ACC_HOLD, SV_NONE};
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/scc_if.sv =====
`default_nettype none
interface scc_in_if import scc_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] dest_x;
    logic signed [COORD_BITS-1:0] dest_y;
    logic signed [COORD_BITS-1:0] body_x;
    logic signed [COORD_BITS-1:0] body_y;
    logic signed [COORD_BITS-1:0] body_z;
    logic                         body_blocks;
    logic                         last_body;

    modport source (
        output valid, start_x, start_y, start_z, dest_x, dest_y,
               body_x, body_y, body_z, body_blocks, last_body,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, dest_x, dest_y,
               body_x, body_y, body_z, body_blocks, last_body,
        output ready
    );
endinterface

interface scc_out_if import scc_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic                         clipped;
    logic signed [COORD_BITS-1:0] clip_x;
    logic signed [COORD_BITS-1:0] clip_y;

    modport source (output valid, clipped, clip_x, clip_y, input ready);
    modport sink (input valid, clipped, clip_x, clip_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/segment_circle_clip.sv =====
// A skipped body or a start inside the circle ends after the first MAC pass;
// a body that reaches the quadratic adds a 50-step square root and a 16-step
// divide. The last body of a move adds a length root, a 24-step margin divide
// and two scaling multiplies when the move is clipped, plus any wait.
// One body at a time: the next body beat is taken only once the last is done.
// Reset: synchronous, active low; config and move state back to defaults, no hit held.
`default_nettype none
module segment_circle_clip import scc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    scc_in_if.sink                     i_in,
    scc_out_if.source                  o_out
);

    // Controller sequences the shared 26x26 multiplier (micro-op table in
    // the package), the iterative square root and the restoring divider.
    // Datapath holds config, the move state (best fraction, hit flag) and
    // the output register, so the next body beat is taken while a result
    // beat still waits for the sink. A last body waits for that register to
    // empty before it produces its own result beat.

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    scc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_in.start_x),
        .i_start_y     (i_in.start_y),
        .i_start_z     (i_in.start_z),
        .i_dest_x      (i_in.dest_x),
        .i_dest_y      (i_in.dest_y),
        .i_body_x      (i_in.body_x),
        .i_body_y      (i_in.body_y),
        .i_body_z      (i_in.body_z),
        .i_body_blocks (i_in.body_blocks),
        .i_last_body   (i_in.last_body),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_clipped     (o_out.clipped),
        .o_clip_x      (o_out.clip_x),
        .o_clip_y      (o_out.clip_y)
    );

endmodule
`default_nettype wire

// ===== rtl/scc_ctrl.sv =====
`default_nettype none
module scc_ctrl import scc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_MAC1  = 17'h00002,
        S_CHK   = 17'h00004,
        S_MAC2  = 17'h00008,
        S_SQI   = 17'h00010,
        S_SQ    = 17'h00020,
        S_NCHK  = 17'h00040,
        S_DIVF  = 17'h00080,
        S_UPD   = 17'h00100,
        S_DONE  = 17'h00200,
        S_FIN   = 17'h00400,
        S_LSQ   = 17'h00800,
        S_DVI   = 17'h01000,
        S_DIVM  = 17'h02000,
        S_STOP  = 17'h04000,
        S_SCALE = 17'h08000,
        S_OUTL  = 17'h10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.step = r_cnt[STEP_W-1:0];
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MAC1;
                end
            end
            S_MAC1: begin
                o_cmd.mac = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == MAC1_LAST) n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.skip) begin
                    n_state = S_DONE;
                end else if (i_sts.c_le0) begin
                    o_cmd.upd_zero = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_cnt   = MAC2_FIRST;
                    n_state = S_MAC2;
                end
            end
            S_MAC2: begin
                o_cmd.mac = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == MAC2_LAST) n_state = S_SQI;
            end
            S_SQI: begin
                if (i_sts.disc_neg) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.sq_init = 1'b1;
                    o_cmd.sq_src  = SQS_DISC;
                    n_cnt         = '0;
                    n_state       = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) n_state = S_NCHK;
            end
            S_NCHK: begin
                if (i_sts.n_ok) begin
                    o_cmd.dv_init = 1'b1;
                    o_cmd.dv_src  = DVS_FRAC;
                    n_cnt         = '0;
                    n_state       = S_DIVF;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIVF: begin
                o_cmd.dv_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == DIVF_LAST) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_div = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                n_state = i_sts.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    if (i_sts.clip) begin
                        o_cmd.sq_init = 1'b1;
                        o_cmd.sq_src  = SQS_LEN;
                        n_cnt         = '0;
                        n_state       = S_LSQ;
                    end else begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_LSQ: begin
                o_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) n_state = S_DVI;
            end
            S_DVI: begin
                o_cmd.dv_init = 1'b1;
                o_cmd.dv_src  = DVS_MARGIN;
                n_cnt         = '0;
                n_state       = S_DIVM;
            end
            S_DIVM: begin
                o_cmd.dv_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == DIVM_LAST) n_state = S_STOP;
            end
            S_STOP: begin
                o_cmd.set_stop = 1'b1;
                n_cnt          = SCALE_FIRST;
                n_state        = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.mac = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == SCALE_LAST) n_state = S_OUTL;
            end
            S_OUTL: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/scc_dp.sv =====
`default_nettype none
module scc_dp import scc_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_start_z,
    input  wire logic signed [COORD_BITS-1:0] i_dest_x,
    input  wire logic signed [COORD_BITS-1:0] i_dest_y,
    input  wire logic signed [COORD_BITS-1:0] i_body_x,
    input  wire logic signed [COORD_BITS-1:0] i_body_y,
    input  wire logic signed [COORD_BITS-1:0] i_body_z,
    input  wire logic                         i_body_blocks,
    input  wire logic                         i_last_body,
    input  wire t_cmd                         i_cmd,
    output t_sts                              o_sts,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_clipped,
    output logic signed [COORD_BITS-1:0]      o_clip_x,
    output logic signed [COORD_BITS-1:0]      o_clip_y
);

    // configuration
    logic [DIST_W-1:0] r_dist, r_height;
    logic [MARG_W-1:0] r_marg, r_minlen;

    // item
    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [DIFF_W-1:0]     r_dx, r_dy, r_fx, r_fy;
    logic [DIFF_W-1:0]            r_zgap;
    logic                         r_blocks, r_last;

    // arithmetic
    logic signed [ACC_W-1:0] r_acc;
    logic [SQ_W-1:0]         r_a, r_hm;
    logic signed [H_W-1:0]   r_c, r_h;
    logic [RAD_W-1:0]        r_rad;
    logic [SREM_W-1:0]       r_srem;
    logic [ROOT_W-1:0]       r_root;
    logic [DREM_W-1:0]       r_drem;
    logic [SQ_W-1:0]         r_div;
    logic [DVD_W-1:0]        r_dvd;
    logic [QUO_W-1:0]        r_quo;
    logic [T_W-1:0]          r_stop;
    logic [COORD_BITS-1:0]   r_x, r_y;

    // move state
    logic [T_W-1:0] r_best;
    logic           r_hit;

    // output register
    logic                         r_ov, r_oc;
    logic signed [COORD_BITS-1:0] r_ox, r_oy;

    t_mop                     w_mop;
    logic signed [MUL_W-1:0]  w_opa, w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_pext, w_term, w_acc_mag;
    logic [PROD_W-1:0]        w_rnd, w_q, w_sq;
    logic [COORD_BITS-1:0]    w_newc;
    logic signed [N_W-1:0]    w_n;
    logic                     w_n_eq_a;
    logic [SREM_W-1:0]        w_stmp, w_trial;
    logic                     w_sge;
    logic [DREM_W-1:0]        w_dtmp;
    logic                     w_dge;
    logic [2*MARG_W-1:0]      w_minsq;
    logic                     w_short;

    assign w_mop = mop_of(i_cmd.step);

    function automatic logic signed [MUL_W-1:0] opnd(input t_opnd sel,
            input logic signed [DIFF_W-1:0] dx, input logic signed [DIFF_W-1:0] dy,
            input logic signed [DIFF_W-1:0] fx, input logic signed [DIFF_W-1:0] fy,
            input logic [DIST_W-1:0] r, input logic [SQ_W-1:0] hm,
            input logic [SQ_W-1:0] a, input logic [SQ_W-1:0] c,
            input logic [T_W-1:0] stop);
        logic signed [MUL_W-1:0] v;
        v = '0;
        case (sel)
            OPD_DX:   v = {dx[DIFF_W-1], dx};
            OPD_DY:   v = {dy[DIFF_W-1], dy};
            OPD_FX:   v = {fx[DIFF_W-1], fx};
            OPD_FY:   v = {fy[DIFF_W-1], fy};
            OPD_R:    v = {{(MUL_W-DIST_W){1'b0}}, r};
            OPD_HL:   v = {1'b0, hm[HALF_W-1:0]};
            OPD_HH:   v = {1'b0, hm[SQ_W-1:HALF_W]};
            OPD_AL:   v = {1'b0, a[HALF_W-1:0]};
            OPD_AH:   v = {1'b0, a[SQ_W-1:HALF_W]};
            OPD_CL:   v = {1'b0, c[HALF_W-1:0]};
            OPD_CH:   v = {1'b0, c[SQ_W-1:HALF_W]};
            OPD_STOP: v = {{(MUL_W-T_W){1'b0}}, stop};
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_opa  = opnd(w_mop.opa, r_dx, r_dy, r_fx, r_fy, r_dist, r_hm, r_a,
                      r_c[SQ_W-1:0], r_stop);
        w_opb  = opnd(w_mop.opb, r_dx, r_dy, r_fx, r_fy, r_dist, r_hm, r_a,
                      r_c[SQ_W-1:0], r_stop);
        w_prod = w_opa * w_opb;
        w_pext = {{(ACC_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};
        case (w_mop.sh)
            SH1:     w_term = w_pext <<< HALF_W;
            SH2:     w_term = w_pext <<< (2 * HALF_W);
            default: w_term = w_pext;
        endcase
    end

    // magnitude of the accumulator: |h|, and |d*stop| for rounding
    assign w_acc_mag = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign w_rnd     = w_acc_mag[PROD_W-1:0] + (PROD_W'(1) << (FRAC_BITS - 1));
    assign w_q       = w_rnd >> FRAC_BITS;
    assign w_sq      = r_acc[ACC_W-1] ? (~w_q + 1'b1) : w_q;
    assign w_newc    = (w_mop.save == SV_X ? r_sx : r_sy) + w_sq[COORD_BITS-1:0];

    // numerator of the hit fraction
    assign w_n      = -$signed({r_h[H_W-1], r_h}) - $signed({2'b00, r_root});
    assign w_n_eq_a = (w_n[N_W-2:0] == {1'b0, r_a});

    assign w_stmp  = {r_srem[SREM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_sge   = (w_stmp >= w_trial);

    assign w_dtmp = {r_drem[DREM_W-2:0], r_dvd[DVD_W-1]};
    assign w_dge  = (w_dtmp >= {1'b0, r_div});

    assign w_minsq = r_minlen * r_minlen;
    assign w_short = (r_a == '0) || (r_a < SQ_W'(w_minsq));

    always_comb begin
        o_sts          = '0;
        o_sts.skip     = w_short || !r_blocks || (r_zgap >= DIFF_W'(r_height));
        o_sts.c_le0    = r_c[H_W-1] || (r_c == '0);
        o_sts.disc_neg = r_acc[ACC_W-1];
        o_sts.n_ok     = !w_n[N_W-1] && (w_n[N_W-2:0] <= {1'b0, r_a});
        o_sts.clip     = r_hit && !w_short;
        o_sts.last     = r_last;
        o_sts.out_busy = r_ov;
    end

    // configuration and move state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist   <= RST_BLOCK_DIST;
            r_height <= RST_BLOCK_HEIGHT;
            r_marg   <= RST_STOP_MARGIN;
            r_minlen <= RST_MIN_LENGTH;
            r_best   <= FRAC_ONE;
            r_hit    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BLOCK_DIST:   r_dist   <= i_cfg_data;
                    REG_BLOCK_HEIGHT: r_height <= i_cfg_data;
                    REG_STOP_MARGIN:  r_marg   <= i_cfg_data[MARG_W-1:0];
                    REG_MIN_LENGTH:   r_minlen <= i_cfg_data[MARG_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.upd_zero && (r_best != '0)) begin
                r_best <= '0;
                r_hit  <= 1'b1;
            end
            if (i_cmd.upd_div && (r_quo[T_W-1:0] < r_best)) begin
                r_best <= r_quo[T_W-1:0];
                r_hit  <= 1'b1;
            end
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            if (i_cmd.out_load) begin
                r_ov   <= 1'b1;
                r_best <= FRAC_ONE;
                r_hit  <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx     <= i_start_x;
            r_sy     <= i_start_y;
            r_ex     <= i_dest_x;
            r_ey     <= i_dest_y;
            r_dx     <= DIFF_W'(i_dest_x) - DIFF_W'(i_start_x);
            r_dy     <= DIFF_W'(i_dest_y) - DIFF_W'(i_start_y);
            r_fx     <= DIFF_W'(i_start_x) - DIFF_W'(i_body_x);
            r_fy     <= DIFF_W'(i_start_y) - DIFF_W'(i_body_y);
            r_zgap   <= (i_body_z >= i_start_z)
                        ? DIFF_W'(i_body_z) - DIFF_W'(i_start_z)
                        : DIFF_W'(i_start_z) - DIFF_W'(i_body_z);
            r_blocks <= i_body_blocks;
            r_last   <= i_last_body;
        end

        if (i_cmd.mac) begin
            case (w_mop.mode)
                ACC_LOAD: r_acc <= w_term;
                ACC_ADD:  r_acc <= r_acc + w_term;
                ACC_SUB:  r_acc <= r_acc - w_term;
                default:  ;
            endcase
            case (w_mop.save)
                SV_A: r_a <= r_acc[SQ_W-1:0];
                SV_C: r_c <= r_acc[H_W-1:0];
                SV_H: begin
                    r_h  <= r_acc[H_W-1:0];
                    r_hm <= w_acc_mag[SQ_W-1:0];
                end
                SV_X:    r_x <= w_newc;
                SV_Y:    r_y <= w_newc;
                default: ;
            endcase
        end

        // square root, two radicand bits a step
        if (i_cmd.sq_init) begin
            r_rad  <= (i_cmd.sq_src == SQS_DISC) ? r_acc[RAD_W-1:0]
                                                 : {{(RAD_W-SQ_W){1'b0}}, r_a};
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_rad  <= r_rad << 2;
            r_srem <= w_sge ? (w_stmp - w_trial) : w_stmp;
            r_root <= {r_root[ROOT_W-2:0], w_sge};
        end

        // restoring divider, one quotient bit a step
        if (i_cmd.dv_init) begin
            if (i_cmd.dv_src == DVS_FRAC) begin
                r_div  <= r_a;
                r_dvd  <= '0;
                r_drem <= w_n_eq_a ? '0 : w_n[DREM_W-1:0];
                r_quo  <= w_n_eq_a ? QUO_W'(1) : '0;
            end else begin
                r_div  <= r_root;
                r_dvd  <= {r_marg, {FRAC_BITS{1'b0}}};
                r_drem <= '0;
                r_quo  <= '0;
            end
        end else if (i_cmd.dv_step) begin
            r_dvd  <= r_dvd << 1;
            r_drem <= w_dge ? (w_dtmp - {1'b0, r_div}) : w_dtmp;
            r_quo  <= {r_quo[QUO_W-2:0], w_dge};
        end

        if (i_cmd.set_stop) begin
            r_stop <= (QUO_W'(r_best) > r_quo) ? (r_best - r_quo[T_W-1:0]) : '0;
        end

        if (i_cmd.out_load) begin
            r_oc <= o_sts.clip;
            r_ox <= o_sts.clip ? r_x : r_ex;
            r_oy <= o_sts.clip ? r_y : r_ey;
        end
    end

    assign o_out_valid = r_ov;
    assign o_clipped   = r_oc;
    assign o_clip_x    = r_ox;
    assign o_clip_y    = r_oy;

endmodule
`default_nettype wire

// ===== rtl/scc_checker.sv =====
`default_nettype none
module scc_checker import scc_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic                  i_clipped,
    input wire logic [COORD_BITS-1:0] i_clip_x,
    input wire logic [COORD_BITS-1:0] i_clip_y
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable({i_clipped, i_clip_x, i_clip_y}))
        else $error("result beat changed while stalled");

    a_one_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second body beat taken while one is in work");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result beat right after a body beat");

endmodule

bind segment_circle_clip scc_checker u_scc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_clipped   (o_out.clipped),
    .i_clip_x    (o_out.clip_x),
    .i_clip_y    (o_out.clip_y)
);
`default_nettype wire

// ===== tb/tb_segment_circle_clip.sv =====
module tb_segment_circle_clip import scc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    // Clipped-move predictor and queue of expected result beats
    class clip_scoreboard;
        typedef struct packed {
            logic                  clipped;
            logic [COORD_BITS-1:0] x;
            logic [COORD_BITS-1:0] y;
        } t_res;

        t_res      pending[$];
        int        errors;
        logic [15:0] dist_r, height_r;
        logic [7:0]  margin_r, minlen_r;
        longint unsigned earliest;
        bit        any_hit;

        function void clear_regs();
            dist_r = RST_BLOCK_DIST;
            height_r = RST_BLOCK_HEIGHT;
            margin_r = RST_STOP_MARGIN;
            minlen_r = RST_MIN_LENGTH;
            earliest = 1 << FRAC_BITS;
            any_hit = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
            case (idx)
                REG_BLOCK_DIST:   dist_r = v;
                REG_BLOCK_HEIGHT: height_r = v;
                REG_STOP_MARGIN:  margin_r = v[7:0];
                REG_MIN_LENGTH:   minlen_r = v[7:0];
                default: ;
            endcase
        endfunction

        // floor square root of a value below 2^126
        function logic [63:0] root_floor(logic [127:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = 0;
            for (int b = 62; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if ({64'd0, t} * {64'd0, t} <= v)
                    r = t;
            end
            return r;
        endfunction

        // d * frac / 2^FRAC_BITS, rounded half away from zero
        function longint scale_by(longint d, longint unsigned f);
            longint p;
            longint unsigned m, q;
            p = d * longint'(f);
            m = (p < 0) ? longint'(-p) : p;
            q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            return (p < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void note_beat(logic signed [COORD_BITS-1:0] sx, sy, sz, ex, ey,
                                bx, by, bz, logic blk, logic lst);
            longint dx, dy, fx, fy, c, h, n, ox, oy;
            longint unsigned a, t, rem, hz, len, mf, stop;
            logic [127:0] hh, ac;
            bit shrt, hit;
            t_res r;
            dx = longint'(ex) - longint'(sx);
            dy = longint'(ey) - longint'(sy);
            a = dx * dx + dy * dy;
            shrt = (a == 0) || (a < longint'(minlen_r) * longint'(minlen_r));
            hz = (longint'(bz) - longint'(sz) < 0) ? longint'(sz) - longint'(bz)
                                                   : longint'(bz) - longint'(sz);
            if (!shrt && blk && hz < height_r) begin
                fx = longint'(sx) - longint'(bx);
                fy = longint'(sy) - longint'(by);
                c = fx * fx + fy * fy - longint'(dist_r) * longint'(dist_r);
                hit = 0;
                t = 0;
                if (c <= 0) begin
                    hit = 1;
                end else begin
                    h = fx * dx + fy * dy;
                    hh = 128'((h < 0) ? -h : h) * 128'((h < 0) ? -h : h);
                    ac = 128'(a) * 128'(c);
                    if (hh >= ac) begin
                        n = -h - longint'(root_floor(hh - ac));
                        if (n >= 0 && longint'(n) <= longint'(a)) begin
                            rem = n % a;
                            t = n / a;
                            for (int i = 0; i < FRAC_BITS; i++) begin
                                rem = rem << 1;
                                t = t << 1;
                                if (rem >= a) begin
                                    rem -= a;
                                    t |= 1;
                                end
                            end
                            hit = 1;
                        end
                    end
                end
                if (hit && t < earliest) begin
                    earliest = t;
                    any_hit = 1;
                end
            end
            if (!lst) return;
            ox = ex;
            oy = ey;
            r.clipped = any_hit && !shrt;
            if (r.clipped) begin
                len = root_floor(128'(a));
                mf = (longint'(margin_r) << FRAC_BITS) / (len != 0 ? len : 1);
                stop = (earliest > mf) ? earliest - mf : 0;
                ox = longint'(sx) + scale_by(dx, stop);
                oy = longint'(sy) + scale_by(dy, stop);
            end
            r.x = ox[COORD_BITS-1:0];
            r.y = oy[COORD_BITS-1:0];
            pending.push_back(r);
            earliest = 1 << FRAC_BITS;
            any_hit = 0;
        endfunction

        function void check_beat(logic cl, logic [COORD_BITS-1:0] x, y);
            t_res e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %0b %h %h", cl, x, y);
                return;
            end
            e = pending.pop_front();
            if (e.clipped !== cl || e.x !== x || e.y !== y) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0b %h %h, got %0b %h %h",
                             e.clipped, e.x, e.y, cl, x, y);
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    scc_in_if  in_ch();
    scc_out_if out_ch();

    segment_circle_clip uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    clip_scoreboard board = new();
    bit  calm;          // no idling in the closing part of the run
    bit  hold_off;      // long receiver stall for back-pressure
    int  accepted;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        in_ch.valid = 0;
        in_ch.start_x = 0; in_ch.start_y = 0; in_ch.start_z = 0;
        in_ch.dest_x = 0;  in_ch.dest_y = 0;
        in_ch.body_x = 0;  in_ch.body_y = 0;  in_ch.body_z = 0;
        in_ch.body_blocks = 0; in_ch.last_body = 0;
        out_ch.ready = 0;
    end

    // Note each accepted input beat; check each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            board.note_beat(in_ch.start_x, in_ch.start_y, in_ch.start_z,
                            in_ch.dest_x, in_ch.dest_y, in_ch.body_x,
                            in_ch.body_y, in_ch.body_z, in_ch.body_blocks,
                            in_ch.last_body);
            accepted++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_beat(out_ch.clipped, out_ch.clip_x, out_ch.clip_y);
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 0;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 0;
                n = $urandom_range(1, 14);
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    // Write enable stays high across a run of writes; the caller drops it
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.write_reg(idx, v);
    endtask

    // Drain, then give the block time to finish a body that yields no result
    task automatic settle();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // Offer one beat; occasional idle gaps before it. Valid stays high
    // between back-to-back beats.
    task automatic send_beat(logic [COORD_BITS-1:0] sx, sy, sz, ex, ey,
                             bx, by, bz, logic blk, logic lst);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.start_x <= sx; in_ch.start_y <= sy; in_ch.start_z <= sz;
        in_ch.dest_x <= ex;  in_ch.dest_y <= ey;
        in_ch.body_x <= bx;  in_ch.body_y <= by;  in_ch.body_z <= bz;
        in_ch.body_blocks <= blk;
        in_ch.last_body <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic idle_input();
        in_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [COORD_BITS-1:0] any_coord();
        return COORD_BITS'($urandom);
    endfunction

    // One move with a few bodies scattered around its path; mostly near,
    // blocking and level so the quadratic is exercised.
    task automatic send_move(int span);
        logic signed [COORD_BITS-1:0] sx, sy, sz, ex, ey, bx, by, bz;
        int nb, pick;
        sx = $urandom_range(0, 2 * span) - span;
        sy = $urandom_range(0, 2 * span) - span;
        sz = $urandom_range(0, 2000) - 1000;
        ex = sx + $urandom_range(0, 2 * span) - span;
        ey = sy + $urandom_range(0, 2 * span) - span;
        nb = $urandom_range(1, 4);
        for (int k = 0; k < nb; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                bx = sx + int'(ex - sx) * int'($urandom_range(0, 12)) / 10
                     + int'($urandom_range(0, 1200)) - 600;
                by = sy + int'(ey - sy) * int'($urandom_range(0, 12)) / 10
                     + int'($urandom_range(0, 1200)) - 600;
                bz = sz + int'($urandom_range(0, 1400)) - 700;
            end else begin
                bx = any_coord(); by = any_coord(); bz = any_coord();
            end
            if (pick == 9) begin
                // noise: full-range move for this body
                send_beat(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                          bx, by, bz, $urandom_range(0, 1), k == nb - 1);
            end else begin
                send_beat(sx, sy, sz, ex, ey, bx, by, bz,
                          $urandom_range(0, 7) != 0, k == nb - 1);
            end
        end
    endtask

    initial begin
        logic [15:0] dist_set[4] = '{16'd512, 16'd0, 16'hFFFF, 16'd1500};
        logic [15:0] high_set[4] = '{16'd512, 16'hFFFF, 16'd0, 16'd900};
        logic [7:0]  marg_set[4] = '{8'd13, 8'd0, 8'hFF, 8'd40};
        logic [7:0]  minl_set[4] = '{8'd3, 8'hFF, 8'd0, 8'd20};
        board.clear_regs();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, short and zero moves, start inside, misses, ties
        send_beat(0, 0, 0, 0, 0, 0, 0, 0, 1, 1);                       // zero move
        send_beat(0, 0, 0, 2, 0, 1, 0, 0, 1, 1);                       // below min length
        send_beat(0, 0, 0, 2560, 0, 100, 0, 0, 1, 1);                  // start inside
        send_beat(0, 0, 0, 2560, 0, 1280, 0, 0, 1, 0);                 // hit ahead
        send_beat(0, 0, 0, 2560, 0, 1280, 0, 0, 1, 1);                 // equal fraction
        send_beat(0, 0, 0, 2560, 0, 1280, 5000, 0, 1, 1);              // miss sideways
        send_beat(0, 0, 0, 2560, 0, 1280, 0, 512, 1, 1);               // height equal limit
        send_beat(0, 0, 0, 2560, 0, 1280, 0, 511, 1, 1);               // just inside height
        send_beat(0, 0, 0, 2560, 0, 1280, 0, 0, 0, 1);                 // not flagged
        send_beat(0, 0, 0, 2560, 0, -1280, 0, 0, 1, 1);                // body behind
        send_beat(0, 0, 0, 2560, 0, 3600, 0, 0, 1, 1);                 // beyond destination
        send_beat(0, 0, 0, 2560, 0, 2000, 0, 0, 1, 0);                 // later, then earlier
        send_beat(0, 0, 0, 2560, 0, 1000, 0, 0, 1, 1);
        send_beat(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                  24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1, 1);
        send_beat(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
                  0, 0, 24'h7FFFFF, 1, 1);
        send_beat(24'h7FFFFF, 24'h800000, 0, 24'h800000, 24'h7FFFFF, 0, 0, 0, 1, 1);
        send_beat(-2560, -2560, -100, 2560, 2560, 0, 0, 0, 1, 0);      // earlier move; its hit carries over
        send_beat(0, 0, 0, 4000, 0, 0, 40000, 0, 1, 1);                // clipped by the carried hit
        idle_input();
        settle();

        // Random phases through register settings, extremes among them
        for (int ph = 0; ph < 5; ph++) begin
            int sel;
            sel = (ph < 4) ? ph : 0;
            cfg_write(REG_BLOCK_DIST, dist_set[sel]);
            cfg_write(REG_BLOCK_HEIGHT, high_set[sel]);
            cfg_write(REG_STOP_MARGIN, {8'd0, marg_set[sel]});
            cfg_write(REG_MIN_LENGTH, {8'd0, minl_set[sel]});
            cfg_write(REG_UNUSED, 16'hFFFF);                           // unused index
            i_cfg_we <= 0;
            if (ph == 1) hold_off = 1;                                 // fill and stall
            if (ph == 4) calm = 1;
            while (accepted < 20 + (ph + 1) * 140)
                send_move(($urandom_range(0, 9) == 0) ? 4000000 : 6000);
            idle_input();
            settle();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("[segment_circle_clip] OK");
        else
            $display("[segment_circle_clip] ERROR");
        $finish;
    end

    initial begin
        #3000000;
        $display("[segment_circle_clip] ERROR");
        $finish;
    end
endmodule
